// ===== rtl/gdfs_pkg.sv =====
`default_nettype none

package gdfs_pkg;

    // Default sizes of the graph store.
    localparam int GDFS_MAX_VERTICES = 16;
    localparam int GDFS_MAX_DEGREE   = 8;

    // Fixed field widths.
    localparam int VTX_W     = 4;
    localparam int LBL_W     = 5;
    localparam int CNT_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // Value of the vertex-count register after reset.
    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(16);

    // Item kinds carried in tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_START,
        S_TOP,
        S_EDGE,
        S_EMIT,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/graph_dfs_depth_labeler_top.sv =====
`default_nettype none

// Depth-first search depth labeler over a small directed graph.
// Input items arrive on the slave stream (i_s_*). tuser carries the item
// kind: 0 appends the edge source -> destination to the source's adjacency
// list, 1 runs a depth-first search from the root given as source. An
// insert item yields one result item with a status. A search item yields
// one result item per vertex in use, carrying the vertex and its depth
// label (root is 1, unreached vertices 0), with tlast on the final one; a
// root out of range yields a single status item instead.
// The vertex-count register is written through the i_cfg_* channel, which
// is always ready; it should only be written while the block is idle.
// Throughput: one item is in flight at a time; a new item is taken only once
// the block is idle again. An insert, or a search whose root is out of range,
// loads its status as a single result item. A search reads the adjacency
// memory for each edge tried and then acts on the neighbour, pops each
// reached vertex from the stack once its edges are done, and then loads one
// result item for each vertex in use.
// Reset (synchronous, active low) empties every adjacency list, clears the
// labels and sets the vertex count to 16. A stall on the master side holds
// the result item in the output register and the search waits on it.
module graph_dfs_depth_labeler_top #(
    parameter int MAX_VERTICES = gdfs_pkg::GDFS_MAX_VERTICES,
    parameter int MAX_DEGREE   = gdfs_pkg::GDFS_MAX_DEGREE
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write channel: vertex count.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gdfs_pkg::CNT_W-1:0]     i_cfg_data,
    // Input items.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata, lowest bit up: source_vertex[3:0], dest_vertex[7:4]
    input  wire logic [gdfs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: op (0 insert, 1 search)
    input  wire logic                           i_s_tuser,
    // Result items.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata, lowest bit up: status[1:0], vertex_index[5:2],
    // depth_label[10:6], zero padding[15:11]
    output logic [gdfs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);
    import gdfs_pkg::*;

    localparam int VCAP   = (MAX_VERTICES < (2 ** VTX_W)) ? MAX_VERTICES : (2 ** VTX_W);
    localparam int VCAP_W = $clog2(VCAP);
    localparam int SP_W   = $clog2(VCAP + 1);
    localparam int DG_W   = $clog2(MAX_DEGREE + 1);
    localparam int ADJ_D  = VCAP * MAX_DEGREE;
    localparam int AW     = $clog2(ADJ_D);
    localparam int PAD_W  = M_TDATA_W - STATUS_W - VTX_W - LBL_W;

    // Control and configuration state.
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_vcount;
    logic [VTX_W-1:0]    r_src, r_dst;
    t_status             r_status;
    logic [SP_W-1:0]     r_sp;
    logic [VTX_W-1:0]    r_idx;

    // Per-vertex state held in flip-flops.
    logic [DG_W-1:0]     r_deg   [VCAP];
    logic [LBL_W-1:0]    r_label [VCAP];
    logic [VCAP_W-1:0]   r_stk_vtx [VCAP];
    logic [DG_W-1:0]     r_stk_pos [VCAP];

    // Adjacency memory, one registered read port.
    logic [VTX_W-1:0]    r_adj_mem [ADJ_D];
    logic [VTX_W-1:0]    r_rd_data;

    // Output register.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [VTX_W-1:0]    r_out_vidx;
    logic [LBL_W-1:0]    r_out_label;
    logic                r_out_last;

    // Strobes from the state machine.
    logic                accept;
    logic                ld_status;
    t_status             new_status;
    logic                mem_we, mem_re;
    logic                start_walk, clr_labels;
    logic                adv_pos, do_push, do_pop;
    logic                ld_out, clr_idx, inc_idx;
    t_status             out_status;
    logic [VTX_W-1:0]    out_vidx;
    logic [LBL_W-1:0]    out_label;
    logic                out_last;

    // Datapath terms.
    logic [CNT_W-1:0]    n_eff;
    logic                out_free;
    logic [VCAP_W-1:0]   src_idx;
    logic [VCAP_W-1:0]   top_idx;
    logic [VCAP_W-1:0]   push_idx;
    logic [VCAP_W-1:0]   v_top;
    logic [DG_W-1:0]     p_top;
    logic [DG_W-1:0]     deg_top;
    logic [VCAP_W-1:0]   w_idx;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                src_ok, dst_ok;
    logic                w_ok;
    logic                idx_last;

    assign n_eff    = (r_vcount > CNT_W'(VCAP)) ? CNT_W'(VCAP) : r_vcount;
    assign out_free = !r_out_valid || i_m_tready;
    assign accept   = i_s_tvalid && o_s_tready;

    assign src_idx  = r_src[VCAP_W-1:0];
    assign top_idx  = VCAP_W'(r_sp - SP_W'(1));
    assign push_idx = VCAP_W'(r_sp);
    assign v_top    = r_stk_vtx[top_idx];
    assign p_top    = r_stk_pos[top_idx];
    assign deg_top  = r_deg[v_top];
    assign w_idx    = r_rd_data[VCAP_W-1:0];

    assign rd_addr  = AW'(v_top) * AW'(MAX_DEGREE) + AW'(p_top);
    assign wr_addr  = AW'(src_idx) * AW'(MAX_DEGREE) + AW'(r_deg[src_idx]);

    assign src_ok   = {1'b0, r_src} < n_eff;
    assign dst_ok   = {1'b0, r_dst} < n_eff;
    // A neighbour is entered only if it is in range, still unlabelled and
    // the stack has room.
    assign w_ok     = ({1'b0, r_rd_data} < n_eff) && (r_label[w_idx] == '0)
                      && (r_sp < SP_W'(VCAP));
    assign idx_last = ({1'b0, r_idx} == (n_eff - CNT_W'(1)));

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        ld_status  = 1'b0;
        new_status = ST_OK;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        start_walk = 1'b0;
        clr_labels = 1'b0;
        adv_pos    = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        ld_out     = 1'b0;
        clr_idx    = 1'b0;
        inc_idx    = 1'b0;
        out_status = ST_OK;
        out_vidx   = '0;
        out_label  = '0;
        out_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_s_tuser == OP_SEARCH) ? S_START : S_INS;
                end
            end
            S_INS: begin
                ld_status = 1'b1;
                n_state   = S_RESP;
                if (!src_ok || !dst_ok) begin
                    new_status = ST_RANGE;
                end else if (r_deg[src_idx] >= DG_W'(MAX_DEGREE)) begin
                    new_status = ST_FULL;
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_START: begin
                clr_labels = 1'b1;
                if (!src_ok) begin
                    ld_status  = 1'b1;
                    new_status = ST_RANGE;
                    n_state    = S_RESP;
                end else begin
                    start_walk = 1'b1;
                    n_state    = S_TOP;
                end
            end
            S_TOP: begin
                if (p_top < deg_top) begin
                    mem_re  = 1'b1;
                    adv_pos = 1'b1;
                    n_state = S_EDGE;
                end else begin
                    do_pop = 1'b1;
                    if (r_sp == SP_W'(1)) begin
                        clr_idx = 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EDGE: begin
                do_push = w_ok;
                n_state = S_TOP;
            end
            S_EMIT: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    out_vidx  = r_idx;
                    out_label = r_label[r_idx[VCAP_W-1:0]];
                    out_last  = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        inc_idx = 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    ld_out     = 1'b1;
                    out_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vcount <= i_cfg_data;
        end
    end

    // Item capture and status.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src <= i_s_tdata[VTX_W-1:0];
            r_dst <= i_s_tdata[2*VTX_W-1:VTX_W];
        end
        if (ld_status) begin
            r_status <= new_status;
        end
        if (clr_idx) begin
            r_idx <= '0;
        end else if (inc_idx) begin
            r_idx <= r_idx + VTX_W'(1);
        end
    end

    // Stack pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (start_walk) begin
            r_sp <= SP_W'(1);
        end else if (do_push) begin
            r_sp <= r_sp + SP_W'(1);
        end else if (do_pop) begin
            r_sp <= r_sp - SP_W'(1);
        end
    end

    // Stack entries.
    always_ff @(posedge i_clk) begin
        if (start_walk) begin
            r_stk_vtx[0] <= src_idx;
            r_stk_pos[0] <= '0;
        end
        if (adv_pos) begin
            r_stk_pos[top_idx] <= p_top + DG_W'(1);
        end
        if (do_push) begin
            r_stk_vtx[push_idx] <= w_idx;
            r_stk_pos[push_idx] <= '0;
        end
    end

    // Degree counts and visit labels. A new vertex sits one place above its
    // parent on the stack, so its label is the stack depth before the push
    // plus one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VCAP; i++) begin
                r_deg[i]   <= '0;
                r_label[i] <= '0;
            end
        end else begin
            if (mem_we) begin
                r_deg[src_idx] <= r_deg[src_idx] + DG_W'(1);
            end
            if (clr_labels) begin
                for (int i = 0; i < VCAP; i++) begin
                    r_label[i] <= '0;
                end
            end
            if (start_walk) begin
                r_label[src_idx] <= LBL_W'(1);
            end
            if (do_push) begin
                r_label[w_idx] <= LBL_W'(r_sp) + LBL_W'(1);
            end
        end
    end

    // Adjacency memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_adj_mem[wr_addr] <= r_dst;
        end
        if (mem_re) begin
            r_rd_data <= r_adj_mem[rd_addr];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_status <= out_status;
            r_out_vidx   <= out_vidx;
            r_out_label  <= out_label;
            r_out_last   <= out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_label, r_out_vidx, r_out_status};
    assign o_m_tlast  = r_out_last;

    // The stack never grows beyond the capped vertex count.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(VCAP))
        else $error("stack pointer beyond capacity");

    // The stack is empty whenever a new item can be taken.
    a_sp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_sp == '0))
        else $error("stack not empty at idle");

    // An edge is only examined with a vertex on the stack.
    a_edge_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_sp != '0))
        else $error("edge step with empty stack");

    // An appended edge never overflows its list.
    a_deg_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_deg[src_idx] < DG_W'(MAX_DEGREE)))
        else $error("adjacency list overflow");

    // A rejected item produces exactly one result item.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[STATUS_W-1:0] != ST_OK)) |-> o_m_tlast)
        else $error("error result without last");

endmodule

`default_nettype wire
